/* sv/nlm_pkg.sv */
// Shared types and constants of the node liveness monitor.
// Used by nlm_cell and node_liveness_monitor_top; depends on nothing else.
package nlm_pkg;

    localparam int MAX_NODES   = 32;
    localparam int TABLE_DEPTH = 32;
    localparam int EPOCH_W     = 31;
    localparam int RANK_W      = 5;
    localparam int COUNT_W     = 6;
    localparam int MASK_W      = 32;
    localparam int AGE_LIMIT   = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Input actions.
    localparam logic [2:0] ACT_RESTART = 3'd0;
    localparam logic [2:0] ACT_TICK    = 3'd1;
    localparam logic [2:0] ACT_HELLO   = 3'd2;
    localparam logic [2:0] ACT_UP      = 3'd3;
    localparam logic [2:0] ACT_DOWN    = 3'd4;
    localparam logic [2:0] ACT_QUERY   = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_HELLO = 2'd0;
    localparam logic [1:0] KIND_UP    = 2'd1;
    localparam logic [1:0] KIND_DOWN  = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_RANK       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRIMARY_PARENT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_PARENT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HAS_PARENT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_CHILDREN  = 3'd5;

    // Operation broadcast to every cell of the chain at once.
    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_RESTART,
        CELL_MARK,
        CELL_HELLO,
        CELL_UP,
        CELL_DOWN,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [RANK_W-1:0]   rank;
        logic [EPOCH_W-1:0]  epoch;
        logic [RANK_W-1:0]   sparent;
        logic [RANK_W-1:0]   own_rank;
        logic [COUNT_W-1:0]  size;
    } cell_cmd_t;

endpackage

/* sv/nlm_cell.sv */
// One cell of the liveness chain: the table entry and up bit of one rank.
// Depends on nlm_pkg for the command struct and field widths.
module nlm_cell
    import nlm_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  logic      init_bit,
    input  logic      pend_in,
    output logic      up,
    output logic      pend
);

    localparam logic [RANK_W-1:0] MY_RANK = RANK_W'(CELL_INDEX);

    logic                valid_reg, valid_next;
    logic                up_reg, up_next;
    logic                pend_reg, pend_next;
    logic [EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic [RANK_W-1:0]   parent_reg, parent_next;
    logic                sel;
    logic                in_range;
    logic                expire;

    assign sel      = (cmd.rank == MY_RANK);
    assign in_range = ({1'b0, MY_RANK} < cmd.size);
    // The lag test is done one bit wider so that epoch + 2 cannot wrap.
    assign expire   = valid_reg &&
                      ({1'b0, cmd.epoch} > ({1'b0, epoch_reg} + (EPOCH_W+1)'(AGE_LIMIT)));

    always_comb
    begin
        valid_next  = valid_reg;
        up_next     = up_reg;
        pend_next   = pend_reg;
        epoch_next  = epoch_reg;
        parent_next = parent_reg;
        unique case (cmd.op)
            CELL_RESTART:
            begin
                valid_next  = init_bit;
                up_next     = 1'b1;
                pend_next   = 1'b0;
                epoch_next  = '0;
                parent_next = init_bit ? cmd.own_rank : '0;
            end
            CELL_MARK:
            begin
                pend_next = expire && in_range;
                if (expire)
                begin
                    valid_next  = 1'b0;
                    epoch_next  = '0;
                    parent_next = '0;
                    if (in_range)
                    begin
                        up_next = 1'b0;
                    end
                end
            end
            CELL_HELLO:
            begin
                if (sel)
                begin
                    valid_next = 1'b1;
                    epoch_next = cmd.epoch;
                    up_next    = 1'b1;
                    if (!valid_reg)
                    begin
                        parent_next = cmd.sparent;
                    end
                end
            end
            CELL_UP:
            begin
                if (sel)
                begin
                    up_next = 1'b1;
                end
                if (valid_reg && parent_reg == cmd.rank)
                begin
                    valid_next  = 1'b0;
                    epoch_next  = '0;
                    parent_next = '0;
                end
            end
            CELL_DOWN:
            begin
                if (sel)
                begin
                    up_next = 1'b0;
                end
            end
            CELL_SHIFT:
            begin
                pend_next = pend_in;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            up_reg    <= 1'b1;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            up_reg    <= up_next;
            pend_reg  <= pend_next;
        end
    end

    // Entry payload is only looked at while the valid bit is set.
    always_ff @(posedge clk)
    begin
        epoch_reg  <= epoch_next;
        parent_reg <= parent_next;
    end

    assign up   = up_reg;
    assign pend = pend_reg;

endmodule

/* sv/node_liveness_monitor_top.sv */
// Top level of the node liveness monitor: configuration registers, control
// sequencer, output register and the chain of nlm_cell entries. Uses nlm_pkg.
//
// Usage. Input items (action, node_rank, epoch_value, sender_parent) enter on
// in_valid when in_stall is low; result items leave on out_valid and are taken
// when out_stall is low, with last set on the final result of an input item.
// Config is written on cfg_valid/cfg_ready (ready always high), cfg_index picks
// the register; the user must write only while the block is idle, unenforced.
//
// Timing. The block works on one item at a time. An item is taken while idle
// and executed in the execute state, which holds while its result cannot enter
// the output register. Restart, up and down give no result; a hello for a
// down rank gives an up notice and a query the up mask. A tick goes on through
// the hello state and one scan step for every rank up to the highest child that
// timed out. The scan shifts the pending-down flag one cell per cycle toward
// cell zero unless a down notice is stalled, so notices leave in ascending rank.
//
// Reset sets every node up, empties the child table, clears the tick age and
// loads the register reset values. When the receiver stalls, the output
// register holds its item and the sequencer waits before the next result; a
// new input item is still taken once the sequencer has finished the last one.
module node_liveness_monitor_top
    import nlm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             action,
    input  logic [RANK_W-1:0]      node_rank,
    input  logic [EPOCH_W-1:0]     epoch_value,
    input  logic [RANK_W-1:0]      sender_parent,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             kind,
    output logic [RANK_W-1:0]      about_rank,
    output logic [EPOCH_W-1:0]     epoch_out,
    output logic [MASK_W-1:0]      up_mask,
    output logic [COUNT_W-1:0]     node_total,
    output logic                   last,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HELLO,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [COUNT_W-1:0]     node_count_reg;
    logic [RANK_W-1:0]      own_rank_reg;
    logic [RANK_W-1:0]      primary_parent_reg;
    logic [RANK_W-1:0]      current_parent_reg;
    logic                   has_parent_reg;
    logic [TABLE_DEPTH-1:0] init_children_reg;

    // The item being worked on.
    logic [2:0]             act_reg;
    logic [RANK_W-1:0]      rank_reg;
    logic [EPOCH_W-1:0]     epoch_reg;
    logic [RANK_W-1:0]      sparent_reg;

    logic [1:0]             tick_age_reg, tick_age_next;
    logic                   hello_pend_reg, hello_pend_next;
    logic [RANK_W-1:0]      scan_idx_reg, scan_idx_next;

    // Output register.
    logic                   out_valid_reg;
    logic [1:0]             kind_reg;
    logic [RANK_W-1:0]      about_reg;
    logic [EPOCH_W-1:0]     epoch_out_reg;
    logic [MASK_W-1:0]      mask_reg;
    logic [COUNT_W-1:0]     total_reg;
    logic                   last_reg;

    // Result the sequencer wants to load this cycle.
    logic                   emit;
    logic                   load;
    logic [1:0]             emit_kind;
    logic [RANK_W-1:0]      emit_about;
    logic [EPOCH_W-1:0]     emit_epoch;
    logic [MASK_W-1:0]      emit_mask;
    logic [COUNT_W-1:0]     emit_total;
    logic                   emit_last;

    logic                   slot_free;
    logic                   accept;
    logic [COUNT_W-1:0]     size;
    logic                   rank_ok;
    logic                   hello_cond;
    logic [TABLE_DEPTH-1:0] up_vec;
    logic [TABLE_DEPTH-1:0] pend_vec;
    logic [TABLE_DEPTH-1:0] pend_shift;
    logic [TABLE_DEPTH-1:0] init_mask;
    logic [TABLE_DEPTH-1:0] range_mask;
    cell_op_t               op_want;
    cell_cmd_t              cmd;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || !out_stall;

    // Node count in use, limited to what the table can hold.
    assign size = (node_count_reg > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                         : node_count_reg;
    assign rank_ok    = ({1'b0, rank_reg} < size);
    assign hello_cond = has_parent_reg && ({1'b0, current_parent_reg} < size) &&
                        up_vec[current_parent_reg];

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            init_mask[i]  = init_children_reg[i] && (i < MAX_NODES);
            range_mask[i] = (COUNT_W'(i) < size);
        end
    end

    // The topmost cell shifts in an empty flag.
    assign pend_shift = {1'b0, pend_vec[TABLE_DEPTH-1:1]};

    always_comb
    begin
        state_next      = state_reg;
        tick_age_next   = tick_age_reg;
        hello_pend_next = hello_pend_reg;
        scan_idx_next   = scan_idx_reg;
        op_want         = CELL_NOP;
        emit            = 1'b0;
        emit_kind       = KIND_HELLO;
        emit_about      = '0;
        emit_epoch      = '0;
        emit_mask       = '0;
        emit_total      = '0;
        emit_last       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                unique case (act_reg)
                    ACT_RESTART:
                    begin
                        op_want       = CELL_RESTART;
                        tick_age_next = '0;
                    end
                    ACT_TICK:
                    begin
                        // The hello test sees the up bits before aging.
                        hello_pend_next = hello_cond;
                        if (tick_age_reg >= 2'(AGE_LIMIT))
                        begin
                            op_want = CELL_MARK;
                        end
                        else
                        begin
                            tick_age_next = tick_age_reg + 2'd1;
                        end
                        state_next = ST_HELLO;
                    end
                    ACT_HELLO:
                    begin
                        if (rank_ok)
                        begin
                            op_want = CELL_HELLO;
                            if (!up_vec[rank_reg])
                            begin
                                emit       = 1'b1;
                                emit_kind  = KIND_UP;
                                emit_about = rank_reg;
                            end
                        end
                    end
                    ACT_UP:
                    begin
                        if (rank_ok)
                        begin
                            op_want = CELL_UP;
                        end
                    end
                    ACT_DOWN:
                    begin
                        if (rank_ok)
                        begin
                            op_want = CELL_DOWN;
                        end
                    end
                    ACT_QUERY:
                    begin
                        emit       = 1'b1;
                        emit_kind  = KIND_QUERY;
                        emit_mask  = MASK_W'(up_vec & range_mask);
                        emit_total = node_count_reg;
                    end
                    default:
                    begin
                    end
                endcase
                // Hold the whole step until the output register can take it.
                if (emit && !slot_free)
                begin
                    state_next      = ST_EXEC;
                    op_want         = CELL_NOP;
                    tick_age_next   = tick_age_reg;
                    hello_pend_next = hello_pend_reg;
                end
            end
            ST_HELLO:
            begin
                scan_idx_next = '0;
                state_next    = ST_SCAN;
                if (hello_pend_reg)
                begin
                    emit       = 1'b1;
                    emit_kind  = KIND_HELLO;
                    emit_about = primary_parent_reg;
                    emit_epoch = epoch_reg;
                    emit_last  = (pend_vec == '0);
                    if (!slot_free)
                    begin
                        state_next = ST_HELLO;
                    end
                end
            end
            ST_SCAN:
            begin
                if (pend_vec == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    emit       = pend_vec[0];
                    emit_kind  = KIND_DOWN;
                    emit_about = scan_idx_reg;
                    emit_last  = (pend_vec[TABLE_DEPTH-1:1] == '0);
                    if (!emit || slot_free)
                    begin
                        op_want       = CELL_SHIFT;
                        scan_idx_next = scan_idx_reg + RANK_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign load = emit && slot_free;

    always_comb
    begin
        cmd.op       = op_want;
        cmd.rank     = rank_reg;
        cmd.epoch    = epoch_reg;
        cmd.sparent  = sparent_reg;
        cmd.own_rank = own_rank_reg;
        cmd.size     = size;
    end

    // The chain: cell i keeps the entry and up bit of rank i.
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        nlm_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .init_bit (init_mask[i]),
            .pend_in  (pend_shift[i]),
            .up       (up_vec[i]),
            .pend     (pend_vec[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            node_count_reg     <= COUNT_W'(32);
            own_rank_reg       <= '0;
            primary_parent_reg <= '0;
            current_parent_reg <= '0;
            has_parent_reg     <= 1'b0;
            init_children_reg  <= '0;
            act_reg            <= '0;
            rank_reg           <= '0;
            epoch_reg          <= '0;
            sparent_reg        <= '0;
            tick_age_reg       <= '0;
            hello_pend_reg     <= 1'b0;
            scan_idx_reg       <= '0;
            out_valid_reg      <= 1'b0;
            kind_reg           <= '0;
            about_reg          <= '0;
            epoch_out_reg      <= '0;
            mask_reg           <= '0;
            total_reg          <= '0;
            last_reg           <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_age_reg   <= tick_age_next;
            hello_pend_reg <= hello_pend_next;
            scan_idx_reg   <= scan_idx_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_NODE_COUNT:     node_count_reg     <= cfg_data[COUNT_W-1:0];
                    REG_OWN_RANK:       own_rank_reg       <= cfg_data[RANK_W-1:0];
                    REG_PRIMARY_PARENT: primary_parent_reg <= cfg_data[RANK_W-1:0];
                    REG_CURRENT_PARENT: current_parent_reg <= cfg_data[RANK_W-1:0];
                    REG_HAS_PARENT:     has_parent_reg     <= cfg_data[0];
                    REG_INIT_CHILDREN:  init_children_reg  <= cfg_data[TABLE_DEPTH-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (accept)
            begin
                act_reg     <= action;
                rank_reg    <= node_rank;
                epoch_reg   <= epoch_value;
                sparent_reg <= sender_parent;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
                kind_reg      <= emit_kind;
                about_reg     <= emit_about;
                epoch_out_reg <= emit_epoch;
                mask_reg      <= emit_mask;
                total_reg     <= emit_total;
                last_reg      <= emit_last;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign about_rank = about_reg;
    assign epoch_out  = epoch_out_reg;
    assign up_mask    = mask_reg;
    assign node_total = total_reg;
    assign last       = last_reg;

endmodule
